### src/cinf_pkg.sv
// shared types, constants and helpers for the 3x3 costmap inflation block
package cinf_pkg;

	// geometry limits
	localparam int DEF_MAX_WIDTH = 512;
	localparam int MAX_HEIGHT    = 4096;

	// field widths
	localparam int COST_W   = 8;
	localparam int WEIGHT_W = 16;
	localparam int MW_W     = 10;
	localparam int MH_W     = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration reset values
	localparam logic [MW_W-1:0]     RST_MAP_WIDTH     = 10'd384;
	localparam logic [MH_W-1:0]     RST_MAP_HEIGHT    = 13'd384;
	localparam logic [COST_W-1:0]   RST_LETHAL_VALUE  = 8'd254;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CENTER = 16'd65024;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT_EDGE   = 16'd8548;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CORNER = 16'd0;

	// result buffer depth, covers the two pipeline stages plus skid room
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH     = 3'd0,
		REG_MAP_HEIGHT    = 3'd1,
		REG_LETHAL_VALUE  = 3'd2,
		REG_WEIGHT_CENTER = 3'd3,
		REG_WEIGHT_EDGE   = 3'd4,
		REG_WEIGHT_CORNER = 3'd5
	} cfg_reg_t;

	// request kind on the cell channel
	typedef enum logic {
		REQ_CELL  = 1'b0,
		REQ_DRAIN = 1'b1
	} req_kind_t;

	// one column of the 3x3 window
	typedef struct packed {
		logic              lower;
		logic [COST_W-1:0] mid;
		logic              upper;
	} win_t;

	// neighbor masks for the output position
	typedef struct packed {
		logic left;
		logic right;
		logic up;
		logic down;
	} nbr_mask_t;

	function automatic logic [WEIGHT_W-1:0] max16(input logic [WEIGHT_W-1:0] a,
		input logic [WEIGHT_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

### src/cinf_ifs.sv
// valid/ready channels: cell requests, inflated results and configuration writes
interface cinf_in_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [cinf_pkg::COST_W-1:0] cell_cost;

	modport source (output valid, output req_type, output cell_cost, input ready);
	modport sink (input valid, input req_type, input cell_cost, output ready);
endinterface

interface cinf_out_if;
	logic                         valid;
	logic                         ready;
	logic [cinf_pkg::WEIGHT_W-1:0] inflated_cost;
	logic                         last_of_frame;

	modport source (output valid, output inflated_cost, output last_of_frame, input ready);
	modport sink (input valid, input inflated_cost, input last_of_frame, output ready);
endinterface

interface cinf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cinf_pkg::CFG_IDX_W-1:0]  index;
	logic [cinf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/costmap_inflation_3x3_top.sv
// 3x3 costmap obstacle inflation over a raster stream of cells
//
// usage:
//   cells   : one request per ready cycle, req_type 0 carries a cell (cell_cost),
//             req_type 1 is a drain request that pushes out pending results
//   results : one inflated 8.8 cost per map cell, last_of_frame on the final one
//   cfg     : register writes (index, data), always ready, write only while idle
// the result for a cell leaves once map_width + 1 further requests have come in;
// after the last cell of a frame, send map_width + 1 drain requests to flush.
// drain requests while cells of the frame are still expected are dropped.
// pipeline: accept -> line memory read -> window / masks -> max select -> buffer;
// the stage 1 and stage 2 registers lie between the request that releases a result
// and its push into the buffer, from which results is driven.
// throughput is one request per cycle while cells.ready holds, set by the line
// memory with one read port and one write port, read and written back once per
// request. when results stalls, the four-entry result buffer absorbs what is in
// flight and cells.ready drops once buffer plus pipeline hold four requests.
// reset clears counters, window and buffer and loads the default registers; the
// line memory is not cleared, its stale entries only feed masked neighbors.
module costmap_inflation_3x3_top #(
	parameter int MAX_WIDTH = cinf_pkg::DEF_MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	cinf_in_if.sink    cells,
	cinf_out_if.source results,
	cinf_cfg_if.sink   cfg
);
	import cinf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);   // column address bits
	localparam int XW = CW + 1;              // room for the width itself
	localparam int RW = 14;                  // input row counter, runs past the height
	localparam int OW = MH_W;                // output row counter
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [CW-1:0]     addr;
		logic [COST_W-1:0] cost;
		logic              lower;
		logic              col0;
		logic              emit;
		nbr_mask_t         mask;
		logic              last;
	} s1_t;

	typedef struct packed {
		win_t      left;
		win_t      center;
		win_t      right;
		nbr_mask_t mask;
		logic      last;
	} s2_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] cost;
		logic                last;
	} res_t;

	// configuration registers
	logic [MW_W-1:0]     map_width_q;
	logic [MH_W-1:0]     map_height_q;
	logic [COST_W-1:0]   lethal_q;
	logic [WEIGHT_W-1:0] w_center_q;
	logic [WEIGHT_W-1:0] w_edge_q;
	logic [WEIGHT_W-1:0] w_corner_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= RST_MAP_WIDTH;
			map_height_q <= RST_MAP_HEIGHT;
			lethal_q     <= RST_LETHAL_VALUE;
			w_center_q   <= RST_WEIGHT_CENTER;
			w_edge_q     <= RST_WEIGHT_EDGE;
			w_corner_q   <= RST_WEIGHT_CORNER;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MAP_WIDTH:     map_width_q  <= cfg.data[MW_W-1:0];
				REG_MAP_HEIGHT:    map_height_q <= cfg.data[MH_W-1:0];
				REG_LETHAL_VALUE:  lethal_q     <= cfg.data[COST_W-1:0];
				REG_WEIGHT_CENTER: w_center_q   <= cfg.data;
				REG_WEIGHT_EDGE:   w_edge_q     <= cfg.data;
				REG_WEIGHT_CORNER: w_corner_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamped geometry
	logic [XW-1:0]   w_eff;
	logic [MH_W-1:0] h_eff;

	always_comb begin
		if (map_width_q == '0) begin
			w_eff = XW'(1);
		end else if (32'(map_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(map_width_q);
		end
		if (map_height_q == '0) begin
			h_eff = MH_W'(1);
		end else if (32'(map_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = MH_W'(MAX_HEIGHT);
		end else begin
			h_eff = map_height_q;
		end
	end

	// position counters
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [OW-1:0] out_row_q;

	// pipeline and buffer control
	logic          s1_v_q;
	s1_t           s1_q;
	logic          s2_v_q;
	s2_t           s2_q;
	logic          fwd_q;
	logic [8:0]    fwd_data_q;
	logic [8:0]    mem_rd_q;
	logic [NW-1:0] fifo_cnt_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	res_t          fifo_q [FIFO_DEPTH];

	// in flight plus buffered must stay within the buffer depth
	logic [NW+1:0] occupancy;
	assign occupancy  = (NW+2)'(fifo_cnt_q) + (NW+2)'(s1_v_q) + (NW+2)'(s2_v_q);
	assign cells.ready = (occupancy < (NW+2)'(FIFO_DEPTH));

	// stage 0: request decode and counter bookkeeping, no memory data needed
	logic          acc;
	logic          draining;
	logic          active;
	logic [COST_W-1:0] cost_in;
	logic          col0;
	logic          emit;
	logic          last;
	nbr_mask_t     mask;
	logic [XW-1:0] col_inc;
	logic [XW-1:0] ocol_inc;
	logic [OW:0]   orow_inc;

	always_comb begin
		acc      = cells.valid && cells.ready;
		draining = (in_row_q >= RW'(h_eff));
		// a drain request while cells are still due changes nothing
		active   = acc && !((req_kind_t'(cells.req_type) == REQ_DRAIN) && !draining);
		cost_in  = draining ? '0 : cells.cell_cost;
		col0     = (in_col_q == '0);
		emit     = col0 ? (in_row_q >= RW'(2)) : (in_row_q >= RW'(1));
		col_inc  = XW'(in_col_q) + XW'(1);
		ocol_inc = XW'(out_col_q) + XW'(1);
		orow_inc = (OW+1)'(out_row_q) + (OW+1)'(1);
		mask.left  = (out_col_q != '0);
		mask.right = (ocol_inc < w_eff);
		mask.up    = (out_row_q != '0);
		mask.down  = (orow_inc < (OW+1)'(h_eff));
		last       = !mask.right && !mask.down;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (active) begin
			if (emit && last) begin
				// frame complete, start over
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_inc >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= col_inc[CW-1:0];
				end
				if (emit) begin
					if (ocol_inc >= w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OW'(1);
					end else begin
						out_col_q <= ocol_inc[CW-1:0];
					end
				end
			end
		end
	end

	// line memory: {lethal flag two rows up, cost one row up} per column
	logic [8:0] line_mem [MAX_WIDTH];
	logic [8:0] rd_entry;
	logic [8:0] wr_entry;
	win_t       incoming;

	assign rd_entry = fwd_q ? fwd_data_q : mem_rd_q;

	always_comb begin
		incoming.upper = rd_entry[8];
		incoming.mid   = rd_entry[COST_W-1:0];
		incoming.lower = s1_q.lower;
		wr_entry       = {(rd_entry[COST_W-1:0] == lethal_q), s1_q.cost};
	end

	always_ff @(posedge clk) begin
		if (s1_v_q) begin
			line_mem[s1_q.addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			mem_rd_q <= line_mem[in_col_q];
		end
	end

	// stage 1 register; forwards a same-column write-back (width one, frame restart)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			s1_v_q <= active;
			if (active) begin
				fwd_q <= s1_v_q && (s1_q.addr == in_col_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			s1_q.addr  <= in_col_q;
			s1_q.cost  <= cost_in;
			s1_q.lower <= !draining && (cost_in == lethal_q);
			s1_q.col0  <= col0;
			s1_q.emit  <= emit;
			s1_q.mask  <= mask;
			s1_q.last  <= last;
			fwd_data_q <= wr_entry;
		end
	end

	// window shift; the emitted triple is the window after the shift,
	// with an empty right column when the emitting request is in column zero
	win_t win_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (s1_v_q) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else begin
			s2_v_q <= s1_v_q && s1_q.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v_q && s1_q.emit) begin
			s2_q.left   <= win_q[1];
			s2_q.center <= win_q[2];
			s2_q.right  <= s1_q.col0 ? '0 : incoming;
			s2_q.mask   <= s1_q.mask;
			s2_q.last   <= s1_q.last;
		end
	end

	// stage 2: only three weight classes, so the max is over four values
	logic                center_l;
	logic                edge_l;
	logic                corner_l;
	logic [WEIGHT_W-1:0] best;

	always_comb begin
		center_l = (s2_q.center.mid == lethal_q);
		edge_l   = (s2_q.mask.up && s2_q.center.upper)
			|| (s2_q.mask.down && s2_q.center.lower)
			|| (s2_q.mask.left && (s2_q.left.mid == lethal_q))
			|| (s2_q.mask.right && (s2_q.right.mid == lethal_q));
		corner_l = (s2_q.mask.left && ((s2_q.mask.up && s2_q.left.upper)
				|| (s2_q.mask.down && s2_q.left.lower)))
			|| (s2_q.mask.right && ((s2_q.mask.up && s2_q.right.upper)
				|| (s2_q.mask.down && s2_q.right.lower)));
		best = {s2_q.center.mid, 8'h00};
		best = max16(best, center_l ? w_center_q : '0);
		best = max16(best, edge_l ? w_edge_q : '0);
		best = max16(best, corner_l ? w_corner_q : '0);
	end

	// result buffer
	logic push;
	logic pop;

	assign push = s2_v_q;
	assign pop  = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].cost <= best;
			fifo_q[wr_ptr_q].last <= s2_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + NW'(push) - NW'(pop);
		end
	end

	assign results.valid         = (fifo_cnt_q != '0);
	assign results.inflated_cost = fifo_q[rd_ptr_q].cost;
	assign results.last_of_frame = fifo_q[rd_ptr_q].last;

	// buffer never overflows: admission counts every request in flight
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q < NW'(FIFO_DEPTH)))
		else $error("result pushed into a full buffer");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= NW'(FIFO_DEPTH))
		else $error("result buffer count out of range");

	// same-column back-to-back access only happens on one-column maps
	// or right after the frame's closing request, which sits in column zero
	a_fwd_width: assert property (@(posedge clk) disable iff (!arst_n)
		(active && s1_v_q && (s1_q.addr == in_col_q))
		|-> ((w_eff == XW'(1)) || (s1_q.emit && s1_q.last)))
		else $error("line memory hazard on a map wider than one column");

	// an emitting request's result goes through stage 1 and stage 2 into the buffer
	a_emit_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(active && emit) |=> ##1 push)
		else $error("emitting request did not reach the result buffer");

endmodule
